[rtl/core/kss_pkg.sv]
`default_nettype none

package kss_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 8;
	localparam int SCORE_W  = 16;
	localparam int RANK_W   = 5;
	localparam int COUNT_W  = 6;

	localparam logic OPC_UPDATE = 1'b0;
	localparam logic OPC_READ   = 1'b1;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_RIGHT,
		CELL_FROM_LEFT,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
	} cell_data_t;

	typedef struct packed {
		cell_op_t           op;
		logic               occ;
		logic [KEY_W-1:0]   probe_key;
		logic [SCORE_W-1:0] probe_score;
	} cell_ctl_t;

	typedef struct packed {
		logic hit;
		logic ge;
	} cell_flags_t;

endpackage

`default_nettype wire

[rtl/core/kss_cell.sv]
`default_nettype none

module kss_cell (
	input  wire                 clk,
	input  kss_pkg::cell_ctl_t  ctl,
	input  kss_pkg::cell_data_t load_data,
	input  kss_pkg::cell_data_t left,
	input  kss_pkg::cell_data_t right,
	output kss_pkg::cell_data_t data,
	output kss_pkg::cell_flags_t flags
);

	kss_pkg::cell_data_t data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			kss_pkg::CELL_HOLD:       data_q <= data_q;
			kss_pkg::CELL_FROM_RIGHT: data_q <= right;
			kss_pkg::CELL_FROM_LEFT:  data_q <= left;
			kss_pkg::CELL_LOAD:       data_q <= load_data;
			default:                  data_q <= data_q;
		endcase
	end

	assign data      = data_q;
	assign flags.hit = ctl.occ && (data_q.key == ctl.probe_key);
	assign flags.ge  = ctl.occ && (data_q.score >= ctl.probe_score);

endmodule

`default_nettype wire

[rtl/core/keyed_score_sorted_table.sv]
`default_nettype none

// Sorted score table held in a row of cells, highest score at rank 0. A read
// request has its result registered at the edge that accepts it. For an update
// request, at the accept edge every cell compares its key with the request key
// and the cells from the match onward shift one place toward rank 0; in the
// next cycle every cell compares its score, and the new entry is written where
// the first lower score stood, or in the first free cell if none is lower,
// while the cells behind it shift one place away from rank 0. An equal score
// lands behind the entries already held. A new key on a full table leaves the
// table as it was and returns rejected. The table is empty after reset and
// needs no clearing pass.
module keyed_score_sorted_table (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         opcode,
	input  wire [kss_pkg::KEY_W-1:0]    player_key,
	input  wire [kss_pkg::SCORE_W-1:0]  new_score,
	input  wire [kss_pkg::RANK_W-1:0]   rank_index,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [kss_pkg::RANK_W-1:0]  placed_rank,
	output logic [kss_pkg::KEY_W-1:0]   entry_key,
	output logic [kss_pkg::SCORE_W-1:0] entry_score,
	output logic                        entry_valid,
	output logic                        rejected,
	output logic [kss_pkg::COUNT_W-1:0] entry_count
);

	typedef enum logic {S_IDLE, S_INSERT} state_t;

	state_t                       state_q;
	logic [kss_pkg::CNT_W-1:0]    count_q;
	logic [kss_pkg::KEY_W-1:0]    key_q;
	logic [kss_pkg::SCORE_W-1:0]  score_q;
	logic                         rej_q;

	kss_pkg::cell_ctl_t   ctl   [kss_pkg::CAPACITY];
	kss_pkg::cell_data_t  cdata [kss_pkg::CAPACITY];
	kss_pkg::cell_flags_t flags [kss_pkg::CAPACITY];
	kss_pkg::cell_data_t  load_data;

	logic                         accept;
	logic                         upd_accept;
	logic                         rd_accept;
	logic                         found;
	logic [kss_pkg::IDX_W-1:0]    found_idx;
	logic [kss_pkg::IDX_W-1:0]    place_idx;
	logic                         full_new;
	kss_pkg::cell_data_t          rd_data;
	logic                         rd_valid;

	assign in_stall   = (state_q != S_IDLE) || (out_valid && out_stall);
	assign accept     = in_valid && !in_stall;
	assign upd_accept = accept && (opcode == kss_pkg::OPC_UPDATE);
	assign rd_accept  = accept && (opcode == kss_pkg::OPC_READ);

	assign load_data.key   = key_q;
	assign load_data.score = score_q;

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		place_idx = '0;
		rd_data   = '0;
		for (int i = 0; i < kss_pkg::CAPACITY; i++) begin
			if (flags[i].hit) begin
				found     = 1'b1;
				found_idx = found_idx | kss_pkg::IDX_W'(i);
			end
			if (ctl[i].op == kss_pkg::CELL_LOAD) begin
				place_idx = place_idx | kss_pkg::IDX_W'(i);
			end
			if (int'(rank_index) == i) begin
				rd_data = cdata[i];
			end
		end
		rd_valid = int'(rank_index) < int'(count_q);
		full_new = !found && (int'(count_q) == kss_pkg::CAPACITY);
	end

	for (genvar i = 0; i < kss_pkg::CAPACITY; i++) begin : g_cell
		kss_pkg::cell_data_t left_d;
		kss_pkg::cell_data_t right_d;
		logic                prev_ge;

		if (i == 0) begin : g_first
			assign left_d  = cdata[i];
			assign prev_ge = 1'b1;
		end else begin : g_mid
			assign left_d  = cdata[i-1];
			assign prev_ge = flags[i-1].ge;
		end

		if (i == kss_pkg::CAPACITY - 1) begin : g_last
			assign right_d = cdata[i];
		end else begin : g_inner
			assign right_d = cdata[i+1];
		end

		always_comb begin
			ctl[i].occ         = int'(count_q) > i;
			ctl[i].probe_key   = player_key;
			ctl[i].probe_score = score_q;
			ctl[i].op          = kss_pkg::CELL_HOLD;
			if (upd_accept && found && (int'(found_idx) <= i)) begin
				ctl[i].op = kss_pkg::CELL_FROM_RIGHT;
			end
			if ((state_q == S_INSERT) && !rej_q && !flags[i].ge) begin
				ctl[i].op = prev_ge ? kss_pkg::CELL_LOAD : kss_pkg::CELL_FROM_LEFT;
			end
		end

		kss_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.load_data (load_data),
			.left      (left_d),
			.right     (right_d),
			.data      (cdata[i]),
			.flags     (flags[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			key_q       <= '0;
			score_q     <= '0;
			rej_q       <= 1'b0;
			out_valid   <= 1'b0;
			placed_rank <= '0;
			entry_key   <= '0;
			entry_score <= '0;
			entry_valid <= 1'b0;
			rejected    <= 1'b0;
			entry_count <= '0;
		end else begin
			if (out_valid && !out_stall && !rd_accept) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rd_accept) begin
						out_valid   <= 1'b1;
						placed_rank <= '0;
						rejected    <= 1'b0;
						entry_valid <= rd_valid;
						entry_key   <= rd_valid ? rd_data.key : '0;
						entry_score <= rd_valid ? rd_data.score : '0;
						entry_count <= kss_pkg::COUNT_W'(count_q);
					end else if (upd_accept) begin
						key_q   <= player_key;
						score_q <= new_score;
						rej_q   <= full_new;
						if (found) begin
							count_q <= count_q - 1'b1;
						end
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					out_valid   <= 1'b1;
					entry_valid <= 1'b0;
					entry_key   <= '0;
					entry_score <= '0;
					rejected    <= rej_q;
					if (rej_q) begin
						placed_rank <= '0;
						entry_count <= kss_pkg::COUNT_W'(count_q);
					end else begin
						placed_rank <= kss_pkg::RANK_W'(place_idx);
						count_q     <= count_q + 1'b1;
						entry_count <= kss_pkg::COUNT_W'(count_q + 1'b1);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[test/keyed_score_sorted_table_tb.sv]
`timescale 1ns / 100ps

module keyed_score_sorted_table_tb;

	import kss_pkg::*;

	localparam int RANDOM_REQUESTS = 500;
	localparam int KEY_POOL        = 40;
	localparam int HOLD_CYCLES     = 120;
	localparam int HOLD_AT         = 150;
	localparam int PAUSE_AT        = 300;
	localparam int STEADY_FROM     = 350;
	localparam int STEADY_TO       = 450;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int DRAIN_CYCLES    = 20;
	localparam int MAX_REPORTS     = 10;

	typedef enum logic {
		OP_UPDATE = OPC_UPDATE,
		OP_READ   = OPC_READ
	} req_op_t;

	typedef struct packed {
		req_op_t             op;
		logic [KEY_W-1:0]    key;
		logic [SCORE_W-1:0]  score;
		logic [RANK_W-1:0]   rank;
	} req_t;

	typedef struct packed {
		logic [RANK_W-1:0]   placed_rank;
		logic [KEY_W-1:0]    entry_key;
		logic [SCORE_W-1:0]  entry_score;
		logic                entry_valid;
		logic                rejected;
		logic [COUNT_W-1:0]  entry_count;
	} resp_t;

	typedef struct packed {
		req_t  rq;
		logic  fixed;
		resp_t rs;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 opcode;
	logic [KEY_W-1:0]     player_key;
	logic [SCORE_W-1:0]   new_score;
	logic [RANK_W-1:0]    rank_index;
	logic                 out_valid;
	logic                 out_stall;
	logic [RANK_W-1:0]    placed_rank;
	logic [KEY_W-1:0]     entry_key;
	logic [SCORE_W-1:0]   entry_score;
	logic                 entry_valid;
	logic                 rejected;
	logic [COUNT_W-1:0]   entry_count;

	logic [KEY_W-1:0]     model_keys [CAPACITY];
	logic [SCORE_W-1:0]   model_scores [CAPACITY];
	int                   model_count;

	resp_t                pending_responses [$];
	row_t                 directed_rows [$];
	int                   mismatches;
	bit                   hold_req;
	bit                   no_idle;

	keyed_score_sorted_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.player_key  (player_key),
		.new_score   (new_score),
		.rank_index  (rank_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.placed_rank (placed_rank),
		.entry_key   (entry_key),
		.entry_score (entry_score),
		.entry_valid (entry_valid),
		.rejected    (rejected),
		.entry_count (entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic string resp_str(input resp_t r);
		return $sformatf("placed=%0d key=%0h score=%0h valid=%0b rej=%0b count=%0d",
			r.placed_rank, r.entry_key, r.entry_score, r.entry_valid, r.rejected,
			r.entry_count);
	endfunction

	task automatic apply_to_table(input req_t rq, output resp_t rs);
		int found;
		int pos;
		int i;
		rs = '0;
		if (rq.op == OP_UPDATE) begin
			found = model_count;
			for (i = 0; i < model_count; i++) begin
				if (model_keys[i] == rq.key) begin
					found = i;
					break;
				end
			end
			if (found < model_count || model_count < CAPACITY) begin
				if (found < model_count) begin
					for (i = found; i + 1 < model_count; i++) begin
						model_keys[i]   = model_keys[i + 1];
						model_scores[i] = model_scores[i + 1];
					end
					model_count--;
				end
				pos = 0;
				while (pos < model_count && model_scores[pos] >= rq.score)
					pos++;
				for (i = model_count; i > pos; i--) begin
					model_keys[i]   = model_keys[i - 1];
					model_scores[i] = model_scores[i - 1];
				end
				model_keys[pos]   = rq.key;
				model_scores[pos] = rq.score;
				model_count++;
				rs.placed_rank = RANK_W'(pos);
			end else begin
				rs.rejected = 1'b1;
			end
		end else if (int'(rq.rank) < model_count) begin
			rs.entry_key   = model_keys[rq.rank];
			rs.entry_score = model_scores[rq.rank];
			rs.entry_valid = 1'b1;
		end
		rs.entry_count = COUNT_W'(model_count);
	endtask

	task automatic send_request(input req_t rq, input logic fixed, input resp_t fixed_rs);
		resp_t predicted;
		while (!no_idle && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= rq.op;
		player_key <= rq.key;
		new_score  <= rq.score;
		rank_index <= rq.rank;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_to_table(rq, predicted);
		pending_responses.push_back(fixed ? fixed_rs : predicted);
		@(negedge clk);
	endtask

	task automatic row_checked(input req_op_t op, input logic [KEY_W-1:0] key,
			input logic [SCORE_W-1:0] score, input logic [RANK_W-1:0] rank);
		row_t row;
		row = '0;
		row.rq = '{op, key, score, rank};
		directed_rows.push_back(row);
	endtask

	task automatic row_fixed(input req_op_t op, input logic [KEY_W-1:0] key,
			input logic [SCORE_W-1:0] score, input logic [RANK_W-1:0] rank,
			input logic [RANK_W-1:0] placed, input logic [KEY_W-1:0] ekey,
			input logic [SCORE_W-1:0] escore, input logic evalid, input logic rej,
			input logic [COUNT_W-1:0] cnt);
		row_t row;
		row.rq    = '{op, key, score, rank};
		row.fixed = 1'b1;
		row.rs    = '{placed, ekey, escore, evalid, rej, cnt};
		directed_rows.push_back(row);
	endtask

	function automatic req_t random_request();
		req_t rq;
		rq.op = ($urandom_range(0, 99) < 65) ? OP_UPDATE : OP_READ;
		if ($urandom_range(0, 99) < 85)
			rq.key = KEY_W'($urandom_range(0, KEY_POOL - 1));
		else
			rq.key = KEY_W'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: rq.score = '0;
			1: rq.score = '1;
			2, 3, 4, 5: rq.score = SCORE_W'($urandom_range(0, 7)) << 13;
			default: rq.score = SCORE_W'($urandom_range(0, 65535));
		endcase
		rq.rank = RANK_W'($urandom_range(0, 31));
		return rq;
	endfunction

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !no_idle && ($urandom_range(0, 99) < 13);
			end
		end
	end

	always @(posedge clk) begin
		resp_t got;
		resp_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{placed_rank, entry_key, entry_score, entry_valid, rejected, entry_count};
			if (pending_responses.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: unexpected response %s", $realtime, resp_str(got));
				mismatches++;
			end else begin
				want = pending_responses.pop_front();
				if (got !== want) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: mismatch exp %s, got %s", $realtime,
							resp_str(want), resp_str(got));
					mismatches++;
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: watchdog expired with %0d responses pending",
			$realtime, pending_responses.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int n;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_UPDATE;
		player_key  = '0;
		new_score   = '0;
		rank_index  = '0;
		mismatches  = 0;
		hold_req    = 1'b0;
		no_idle     = 1'b0;
		model_count = 0;
		foreach (model_keys[i]) begin
			model_keys[i]   = '0;
			model_scores[i] = '0;
		end

		row_fixed(OP_READ,   8'h00, 16'h0000, 5'd0,  5'd0, 8'h00, 16'h0000, 1'b0, 1'b0, 6'd0);
		row_fixed(OP_READ,   8'h00, 16'h0000, 5'd31, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0, 6'd0);
		row_fixed(OP_UPDATE, 8'h00, 16'h0000, 5'd0,  5'd0, 8'h00, 16'h0000, 1'b0, 1'b0, 6'd1);
		row_fixed(OP_UPDATE, 8'hFF, 16'hFFFF, 5'd31, 5'd0, 8'h00, 16'h0000, 1'b0, 1'b0, 6'd2);
		row_fixed(OP_READ,   8'h00, 16'h0000, 5'd0,  5'd0, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 6'd2);
		row_fixed(OP_READ,   8'hFF, 16'hFFFF, 5'd1,  5'd0, 8'h00, 16'h0000, 1'b1, 1'b0, 6'd2);
		row_fixed(OP_READ,   8'h00, 16'h0000, 5'd2,  5'd0, 8'h00, 16'h0000, 1'b0, 1'b0, 6'd2);
		row_fixed(OP_UPDATE, 8'h55, 16'h8000, 5'd0,  5'd1, 8'h00, 16'h0000, 1'b0, 1'b0, 6'd3);
		row_fixed(OP_UPDATE, 8'hAA, 16'h8000, 5'd0,  5'd2, 8'h00, 16'h0000, 1'b0, 1'b0, 6'd4);
		row_checked(OP_UPDATE, 8'h55, 16'h8000, 5'd0);
		row_checked(OP_UPDATE, 8'h00, 16'hFFFF, 5'd0);
		row_checked(OP_UPDATE, 8'hFF, 16'h0000, 5'd0);
		row_checked(OP_READ,   8'h00, 16'h0000, 5'd0);
		row_checked(OP_READ,   8'h00, 16'h0000, 5'd1);
		row_checked(OP_READ,   8'h00, 16'h0000, 5'd2);
		row_checked(OP_READ,   8'h00, 16'h0000, 5'd3);
		row_checked(OP_UPDATE, 8'h12, 16'h1234, 5'd0);
		row_checked(OP_UPDATE, 8'hAA, 16'h7FFF, 5'd0);
		row_checked(OP_READ,   8'h00, 16'h0000, 5'd31);
		row_checked(OP_READ,   8'h00, 16'h0000, 5'd4);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].rq, directed_rows[i].fixed, directed_rows[i].rs);

		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == HOLD_AT)
				hold_req = 1'b1;
			if (n == PAUSE_AT) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending_responses.size() != 0);
			end
			no_idle = (n >= STEADY_FROM && n < STEADY_TO);
			send_request(random_request(), 1'b0, '0);
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		while (pending_responses.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_responses.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
